/* hdl/lruc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
package lruc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    // One request: lookup or store
    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    // One response
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value_out;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_rsp;

    // Per-slot update controls from the cache control
    typedef struct packed {
        logic wr_key;
        logic wr_data;
        logic set_valid;
        logic zero_rec;
        logic inc_rec;
    } t_slot_ctl;

    // Per-slot status towards the cache control
    typedef struct packed {
        logic valid;
        logic match;
        logic oldest;
    } t_slot_stat;

endpackage

/* hdl/lruc_slot.sv */
// One entry of the cache: key, data, valid mark and recency rank.
// Depends on lruc_pkg for the control and status structs.
module lruc_slot import lruc_pkg::*; #(
    parameter int REC_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_slot_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_value,
    input  logic [REC_W-1:0] i_occ_m1,
    output t_slot_stat       o_stat,
    output logic [KEY_W-1:0] o_key,
    output logic [VAL_W-1:0] o_value,
    output logic [REC_W-1:0] o_rec
);

    logic             r_valid;
    logic [REC_W-1:0] r_rec;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_data;

    // Valid mark and age rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rec   <= '0;
        end else begin
            if (i_ctl.set_valid) begin
                r_valid <= 1'b1;
            end
            if (i_ctl.zero_rec) begin
                r_rec <= '0;
            end else if (i_ctl.inc_rec) begin
                r_rec <= r_rec + REC_W'(1);
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_key) begin
            r_key <= i_key;
        end
        if (i_ctl.wr_data) begin
            r_data <= i_value;
        end
    end

    // Oldest valid entry holds rank occupancy-1
    assign o_stat.valid  = r_valid;
    assign o_stat.match  = r_valid && (r_key == i_key);
    assign o_stat.oldest = r_valid && (r_rec == i_occ_m1);
    assign o_key         = r_key;
    assign o_value       = r_data;
    assign o_rec         = r_rec;

endmodule

/* hdl/lru_key_value_cache_unit.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lruc_pkg and lruc_slot.
//
// Accepts one get or put request per clock while the response side is not
// stalled and returns one response per request. Each response goes through
// the request and then the response register and holds while stalled.
// Every request does one parallel key compare across all ENTRIES slots and
// one recency-rank update in one pass, which sets the one-request-per-cycle
// rate. Valid marks are cleared by reset at once, so the cache is usable in
// the cycle after reset. A get hit returns the stored value; a miss returns
// hit 0 and value 0. A put of a new key when the cache holds capacity entries
// evicts the least recent entry and reports its key. Capacity (0 acts as 1,
// above ENTRIES acts as ENTRIES) is written through i_cfg_we/i_cfg_wdata; the
// user writes it while the cache is idle; the block does not enforce it.
module lru_key_value_cache_unit import lruc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_req_valid,
    input  t_req             i_req,
    output logic             o_req_stall,
    output logic             o_rsp_valid,
    output t_rsp             o_rsp,
    input  logic             i_rsp_stall
);

    localparam int REC_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic             r_in_valid;
    t_req             r_in;
    logic             r_out_valid;
    t_rsp             r_out;
    t_rsp             n_rsp;

    t_slot_ctl        s_ctl  [ENTRIES];
    t_slot_stat       s_stat [ENTRIES];
    logic [KEY_W-1:0] s_key  [ENTRIES];
    logic [VAL_W-1:0] s_data [ENTRIES];
    logic [REC_W-1:0] s_rec  [ENTRIES];

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_low;
    logic [ENTRIES-1:0] sel_vec;

    logic             adv;
    logic             fire;
    logic             hit;
    logic             is_put;
    logic             full;
    logic             do_touch;
    logic             do_evict;
    logic             do_insert;
    logic [REC_W-1:0] occ_m1;
    logic [REC_W-1:0] found_rec;
    logic [REC_W-1:0] thr;
    logic [VAL_W-1:0] found_data;
    logic [KEY_W-1:0] oldest_key;

    // Handshake: response register frees up or is being taken
    assign adv         = !r_out_valid || !i_rsp_stall;
    assign fire        = r_in_valid && adv;
    assign o_req_stall = r_in_valid && !adv;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_req_stall) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_req_stall && i_req_valid) begin
            r_in <= i_req;
        end
    end

    // Entry slots
    for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
        lruc_slot #(
            .REC_W (REC_W)
        ) u_slot (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (s_ctl[g]),
            .i_key    (r_in.key),
            .i_value  (r_in.value),
            .i_occ_m1 (occ_m1),
            .o_stat   (s_stat[g]),
            .o_key    (s_key[g]),
            .o_value  (s_data[g]),
            .o_rec    (s_rec[g])
        );
    end

    // Gather slot status; one-hot reads of the hit and oldest entries
    always_comb begin
        found_data = '0;
        oldest_key = '0;
        found_rec  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid_vec[i]  = s_stat[i].valid;
            match_vec[i]  = s_stat[i].match;
            oldest_vec[i] = s_stat[i].oldest;
            found_data    = found_data | ({VAL_W{match_vec[i]}} & s_data[i]);
            found_rec     = found_rec | ({REC_W{match_vec[i]}} & s_rec[i]);
            oldest_key    = oldest_key | ({KEY_W{oldest_vec[i]}} & s_key[i]);
        end
    end

    // Lowest free slot
    assign free_vec = ~valid_vec;
    assign free_low = free_vec & (~free_vec + ENTRIES'(1));

    // Decision for the request in the request register
    assign occ_m1 = REC_W'(r_occ - OCC_W'(1));
    assign hit    = |match_vec;
    assign is_put = (r_in.opcode == OP_PUT);
    assign full   = ((r_cap != '0) && (CMP_W'(r_occ) >= CMP_W'(r_cap)))
                 || ((r_cap == '0) && (r_occ != '0))
                 || (r_occ == OCC_W'(ENTRIES));

    assign do_touch  = fire && hit;
    assign do_evict  = fire && !hit && is_put && full;
    assign do_insert = fire && !hit && is_put && !full;

    assign sel_vec = hit ? match_vec : (full ? oldest_vec : free_low);
    assign thr     = hit ? found_rec : occ_m1;

    // Per-slot controls: chosen slot becomes most recent, younger ones age
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            s_ctl[i].wr_key    = (do_evict || do_insert) && sel_vec[i];
            s_ctl[i].wr_data   = (do_evict || do_insert || (do_touch && is_put))
                              && sel_vec[i];
            s_ctl[i].set_valid = do_insert && sel_vec[i];
            s_ctl[i].zero_rec  = (do_touch || do_evict || do_insert) && sel_vec[i];
            if (do_touch || do_evict) begin
                s_ctl[i].inc_rec = valid_vec[i] && !sel_vec[i] && (s_rec[i] < thr);
            end else begin
                s_ctl[i].inc_rec = do_insert && valid_vec[i];
            end
        end
    end

    // Occupancy count
    assign n_occ = do_insert ? (r_occ + OCC_W'(1)) : r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Response fields
    always_comb begin
        n_rsp.hit         = hit;
        n_rsp.value_out   = (hit && !is_put) ? found_data : '0;
        n_rsp.evicted     = !hit && is_put && full;
        n_rsp.evicted_key = (!hit && is_put && full) ? oldest_key : '0;
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_rsp;
        end
    end

endmodule

/* hdl/lruc_checker.sv */
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lruc_pkg and lru_key_value_cache_unit.
module lruc_checker import lruc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_rsp_valid,
    input t_rsp o_rsp,
    input logic i_rsp_stall
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // Evicted key is zero unless an eviction is reported
    a_evkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.evicted |-> o_rsp.evicted_key == '0)
        else $error("evicted key without eviction");

    // Eviction only on a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.evicted |-> !o_rsp.hit)
        else $error("eviction reported on a hit");

    // A non-zero value comes only from a hit
    a_value_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.value_out != '0) |-> o_rsp.hit)
        else $error("value returned on a miss");

    // No response straight after reset
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp_valid)
        else $error("response valid after reset");

endmodule

bind lru_key_value_cache_unit lruc_checker u_lruc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp),
    .i_rsp_stall (i_rsp_stall)
);
